### design/rumble_report_framer_macros.svh
// ---------------------------------------------------------------------------
// Rumble report framer assertion macros
// Shared concurrent assertion forms for the framer modules.
// ---------------------------------------------------------------------------
`ifndef RUMBLE_REPORT_FRAMER_MACROS_SVH
`define RUMBLE_REPORT_FRAMER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RRF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define RRF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RRF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define RRF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### design/rrf_pkg.sv
// ---------------------------------------------------------------------------
// Rumble report framer package
// Payload types, report layout constants and the CRC-32 byte update.
// ---------------------------------------------------------------------------
package rrf_pkg;

	localparam int PAIR_W = 6;

	localparam logic [PAIR_W-1:0] USB_LAST_PAIR = PAIR_W'(48 / 2 - 1);
	localparam logic [PAIR_W-1:0] BT_LAST_PAIR  = PAIR_W'(78 / 2 - 1);
	localparam logic [PAIR_W-1:0] BT_CRC_LO_PAIR = PAIR_W'(74 / 2);
	localparam logic [PAIR_W-1:0] PAIR_HDR = PAIR_W'(0);
	localparam logic [PAIR_W-1:0] PAIR_ONE = PAIR_W'(1);
	localparam logic [PAIR_W-1:0] PAIR_TWO = PAIR_W'(2);

	localparam logic [7:0] USB_REPORT_ID = 8'h02;
	localparam logic [7:0] BT_REPORT_ID  = 8'h31;
	localparam logic [7:0] BT_REPORT_TAG = 8'h02;
	localparam logic [7:0] MOTOR_FLAGS   = 8'h03;
	localparam logic [7:0] CRC_SEED_BYTE = 8'hA2;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	localparam logic MODE_USB = 1'b0;
	localparam logic MODE_BT  = 1'b1;

	typedef struct packed {
		logic [7:0] left_motor;
		logic [7:0] right_motor;
		logic       force_send;
	} rrf_in_t;

	typedef struct packed {
		logic [7:0] byte_even;
		logic [7:0] byte_odd;
		logic       last_pair;
	} rrf_out_t;

	typedef struct packed {
		logic load;
		logic emit;
	} rrf_cmd_t;

	typedef struct packed {
		logic differ;
		logic last;
		logic slot_free;
	} rrf_status_t;

	function automatic logic [31:0] crc_tab(input logic [7:0] idx);
		logic [31:0] c;
		c = {24'd0, idx};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
		end
		return c;
	endfunction

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		return (c >> 8) ^ crc_tab(c[7:0] ^ b);
	endfunction

	localparam logic [31:0] CRC_AFTER_SEED = crc_byte(CRC_INIT, CRC_SEED_BYTE);

endpackage

### design/rumble_report_framer.sv
// ---------------------------------------------------------------------------
// Rumble report framer
// Turns motor intensity updates into USB or Bluetooth output reports.
// ---------------------------------------------------------------------------
//  Channel  Handshake            Beat
//  cfg      cfg_we               transport mode bit
//  in       in_valid / in_stall  left, right, force
//  out      out_valid / out_stall byte pair and last flag
//
// An accepted beat that needs no report is absorbed and the input stays ready.
// A beat that needs a report is accepted and then sent as 24 byte pairs in
// USB mode or 39 in Bluetooth mode, where the running CRC-32 takes two bytes
// per pair.
// The input stalls while a report is being sent; the output register lets
// the next beat enter while the final pair still waits.
// Output stalls hold the pair counter and the CRC. Reset clears the stored
// intensities and selects USB mode.
`include "rumble_report_framer_macros.svh"

module rumble_report_framer
	import rrf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  logic     cfg_data,
	input  logic     in_valid,
	output logic     in_stall,
	input  rrf_in_t  in_data,
	output logic     out_valid,
	input  logic     out_stall,
	output rrf_out_t out_data
);

	rrf_cmd_t    cmd;
	rrf_status_t status;

	rrf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.force_send (in_data.force_send),
		.status     (status),
		.in_stall   (in_stall),
		.cmd        (cmd)
	);

	rrf_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

### design/rrf_ctrl.sv
// ---------------------------------------------------------------------------
// Rumble report framer controller
// Accepts an input beat, decides whether a report is due, and paces pairs.
// ---------------------------------------------------------------------------
`include "rumble_report_framer_macros.svh"

module rrf_ctrl
	import rrf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        force_send,
	input  rrf_status_t status,
	output logic        in_stall,
	output rrf_cmd_t    cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_SEND
	} state_t;

	state_t state_q;

	always_comb begin
		in_stall = (state_q != ST_IDLE);
		cmd.load = (state_q == ST_IDLE) && in_valid && (status.differ || force_send);
		cmd.emit = (state_q == ST_SEND) && status.slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_SEND;
					end
				end
				ST_SEND: begin
					if (cmd.emit && status.last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`RRF_ASSERT_IMP(a_emit_only_sending, clk, arst_n, cmd.emit, state_q == ST_SEND, "emit outside send")
	`RRF_ASSERT_NXT(a_load_starts_send, clk, arst_n, cmd.load, in_stall, "load did not start a report")
	`RRF_ASSERT_IMP(a_no_load_busy, clk, arst_n, cmd.load, !in_stall, "load while busy")

endmodule

### design/rrf_datapath.sv
// ---------------------------------------------------------------------------
// Rumble report framer datapath
// Stored intensities, pair counter, running CRC-32 and the output register.
// ---------------------------------------------------------------------------
`include "rumble_report_framer_macros.svh"

module rrf_datapath
	import rrf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_data,
	input  rrf_in_t     in_data,
	input  logic        out_stall,
	input  rrf_cmd_t    cmd,
	output rrf_status_t status,
	output logic        out_valid,
	output rrf_out_t    out_data
);

	logic              mode_q;
	logic [7:0]        prev_left_q;
	logic [7:0]        prev_right_q;
	logic [PAIR_W-1:0] pair_q;
	logic [31:0]       crc_q;
	logic              out_valid_q;
	rrf_out_t          out_q;

	logic [7:0]  b_even;
	logic [7:0]  b_odd;
	logic        is_last;
	logic [31:0] crc_fin;
	logic [31:0] crc_next;

	always_comb begin
		b_even  = 8'd0;
		b_odd   = 8'd0;
		crc_fin = ~crc_q;
		if (mode_q == MODE_USB) begin
			is_last = (pair_q == USB_LAST_PAIR);
			if (pair_q == PAIR_HDR) begin
				b_even = USB_REPORT_ID;
				b_odd  = MOTOR_FLAGS;
			end else if (pair_q == PAIR_ONE) begin
				b_odd = prev_right_q;
			end else if (pair_q == PAIR_TWO) begin
				b_even = prev_left_q;
			end
		end else begin
			is_last = (pair_q == BT_LAST_PAIR);
			if (pair_q == PAIR_HDR) begin
				b_even = BT_REPORT_ID;
				b_odd  = BT_REPORT_TAG;
			end else if (pair_q == PAIR_ONE) begin
				b_even = MOTOR_FLAGS;
			end else if (pair_q == PAIR_TWO) begin
				b_even = prev_right_q;
				b_odd  = prev_left_q;
			end else if (pair_q == BT_CRC_LO_PAIR) begin
				b_even = crc_fin[7:0];
				b_odd  = crc_fin[15:8];
			end else if (pair_q == BT_LAST_PAIR) begin
				b_even = crc_fin[23:16];
				b_odd  = crc_fin[31:24];
			end
		end
		crc_next = crc_byte(crc_byte(crc_q, b_even), b_odd);
	end

	always_comb begin
		status.differ    = (in_data.left_motor != prev_left_q) ||
		                   (in_data.right_motor != prev_right_q);
		status.last      = is_last;
		status.slot_free = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_USB;
			prev_left_q  <= 8'd0;
			prev_right_q <= 8'd0;
			pair_q       <= PAIR_HDR;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_data;
			end
			if (cmd.load) begin
				prev_left_q  <= in_data.left_motor;
				prev_right_q <= in_data.right_motor;
				pair_q       <= PAIR_HDR;
			end else if (cmd.emit) begin
				pair_q <= is_last ? PAIR_HDR : pair_q + PAIR_ONE;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			crc_q <= CRC_AFTER_SEED;
		end else if (cmd.emit && (pair_q < BT_CRC_LO_PAIR)) begin
			crc_q <= crc_next;
		end
		if (cmd.emit) begin
			out_q.byte_even <= b_even;
			out_q.byte_odd  <= b_odd;
			out_q.last_pair <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`RRF_ASSERT_NXT(a_load_clears_pair, clk, arst_n, cmd.load, pair_q == PAIR_HDR, "pair not reset")
	`RRF_ASSERT_IMP(a_pair_in_range, clk, arst_n, 1'b1, pair_q <= BT_LAST_PAIR, "pair overrun")
	`RRF_ASSERT_NXT(a_last_flagged, clk, arst_n, cmd.emit && is_last, out_valid && out_data.last_pair, "last pair lost")

endmodule

### test/rumble_report_framer_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Rumble report framer testbench
// Drives motor updates through six phases: three idle patterns of both
// channels, each in both transport modes. Each accepted update that needs a
// report is framed by a local USB or Bluetooth report builder with a bitwise
// CRC-32; every output beat is checked against the oldest predicted byte pair.
// ---------------------------------------------------------------------------
module rumble_report_framer_tb;
	import rrf_pkg::*;

	localparam int USB_REPORT_LEN = 48;
	localparam int BT_REPORT_LEN = 78;
	localparam int BT_CRC_SPAN = 74;
	localparam int RANDOM_PER_PHASE = 35;
	localparam int STUCK_LIMIT = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_data = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	rrf_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	rrf_out_t out_data;

	rrf_in_t update_q[$];
	rrf_out_t pair_q[$];

	logic mode_sel = MODE_USB;
	logic [7:0] held_left = 8'd0;
	logic [7:0] held_right = 8'd0;
	logic [7:0] gen_left = 8'd0;
	logic [7:0] gen_right = 8'd0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;
	int stuck_cycles = 0;

	rumble_report_framer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	function automatic void frame_report(input rrf_in_t upd);
		logic [7:0] rep [0:BT_REPORT_LEN-1];
		logic [31:0] crc;
		int len;
		rrf_out_t pair;
		if (upd.left_motor == held_left && upd.right_motor == held_right && !upd.force_send) begin
			return;
		end
		held_left = upd.left_motor;
		held_right = upd.right_motor;
		for (int i = 0; i < BT_REPORT_LEN; i++) begin
			rep[i] = 8'd0;
		end
		if (mode_sel == MODE_USB) begin
			len = USB_REPORT_LEN;
			rep[0] = USB_REPORT_ID;
			rep[1] = MOTOR_FLAGS;
			rep[3] = upd.right_motor;
			rep[4] = upd.left_motor;
		end else begin
			len = BT_REPORT_LEN;
			rep[0] = BT_REPORT_ID;
			rep[1] = BT_REPORT_TAG;
			rep[2] = MOTOR_FLAGS;
			rep[4] = upd.right_motor;
			rep[5] = upd.left_motor;
			crc = crc32_step(CRC_INIT, CRC_SEED_BYTE);
			for (int i = 0; i < BT_CRC_SPAN; i++) begin
				crc = crc32_step(crc, rep[i]);
			end
			crc = ~crc;
			rep[BT_CRC_SPAN] = crc[7:0];
			rep[BT_CRC_SPAN+1] = crc[15:8];
			rep[BT_CRC_SPAN+2] = crc[23:16];
			rep[BT_CRC_SPAN+3] = crc[31:24];
		end
		for (int p = 0; p < len / 2; p++) begin
			pair.byte_even = rep[2*p];
			pair.byte_odd = rep[2*p+1];
			pair.last_pair = (p == len / 2 - 1);
			pair_q.push_back(pair);
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				frame_report(in_data);
				void'(update_q.pop_front());
			end
			if (!in_valid || !in_stall) begin
				if (update_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= update_q[0];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : pair_monitor
		rrf_out_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
			if (out_valid && !out_stall) begin
				if (pair_q.size() == 0) begin
					$display("%0t: beat with no report pending, expected none, got %h",
						$time, out_data);
					errors++;
				end else begin
					want = pair_q.pop_front();
					if (out_data.byte_even !== want.byte_even) begin
						$display("%0t: byte_even expected %h, got %h",
							$time, want.byte_even, out_data.byte_even);
						errors++;
					end
					if (out_data.byte_odd !== want.byte_odd) begin
						$display("%0t: byte_odd expected %h, got %h",
							$time, want.byte_odd, out_data.byte_odd);
						errors++;
					end
					if (out_data.last_pair !== want.last_pair) begin
						$display("%0t: last_pair expected %b, got %b",
							$time, want.last_pair, out_data.last_pair);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)
				|| (update_q.size() == 0 && pair_q.size() == 0)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles == STUCK_LIMIT) begin
				$display("rumble_report_framer: mismatch");
				$finish;
			end
		end
	end

	task automatic queue_update(input logic [7:0] l, input logic [7:0] r, input logic f);
		rrf_in_t upd;
		upd.left_motor = l;
		upd.right_motor = r;
		upd.force_send = f;
		gen_left = l;
		gen_right = r;
		update_q.push_back(upd);
	endtask

	task automatic queue_directed();
		queue_update(8'h00, 8'h00, 1'b0);
		queue_update(8'h00, 8'h00, 1'b1);
		queue_update(8'hFF, 8'hFF, 1'b0);
		queue_update(8'hFF, 8'hFF, 1'b0);
		queue_update(8'hFF, 8'hFF, 1'b1);
		queue_update(8'h00, 8'hFF, 1'b0);
		queue_update(8'hFF, 8'h00, 1'b0);
		queue_update(8'h55, 8'hAA, 1'b0);
		queue_update(8'hAA, 8'h55, 1'b1);
		queue_update(8'h01, 8'h80, 1'b0);
		queue_update(8'h80, 8'h01, 1'b0);
		queue_update(8'h00, 8'h00, 1'b0);
	endtask

	task automatic queue_random(input int count);
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 25) begin
				queue_update(gen_left, gen_right, 1'($urandom_range(1)));
			end else if (pick < 35) begin
				queue_update($urandom_range(1) ? 8'hFF : 8'h00,
					$urandom_range(1) ? 8'hFF : 8'h00, $urandom_range(3) == 0);
			end else begin
				queue_update(8'($urandom_range(255)), 8'($urandom_range(255)),
					$urandom_range(3) == 0);
			end
		end
	endtask

	task automatic write_mode(input logic m);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		mode_sel = m;
	endtask

	initial begin
		logic phase_mode [0:5];
		phase_mode = '{MODE_USB, MODE_BT, MODE_BT, MODE_USB, MODE_USB, MODE_BT};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < 6; ph++) begin
			write_mode(phase_mode[ph]);
			case (ph / 2)
				0: begin
					send_idle_pct = 13;
					recv_stall_pct = 85;
				end
				1: begin
					send_idle_pct = 85;
					recv_stall_pct = 13;
				end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			@(negedge clk);
			if (ph < 2) begin
				queue_directed();
			end
			queue_random(RANDOM_PER_PHASE);
			while (update_q.size() != 0 || pair_q.size() != 0) begin
				@(posedge clk);
			end
			repeat (6) @(posedge clk);
		end
		repeat (40) @(posedge clk);
		if (errors == 0) begin
			$display("rumble_report_framer: match");
		end else begin
			$display("rumble_report_framer: mismatch");
		end
		$finish;
	end

endmodule
